FILE: hdl/hcrac_pkg.sv
// hcrac_pkg: shared types and constants of the hypercube right-angle counter
// used by every module of the block but hcrac_ram; no dependencies

package hcrac_pkg;

    // fixed field widths of the stream items and the register
    localparam int KIND_W       = 2;
    localparam int INDEX_W      = 6;
    localparam int VERTEX_W     = 32;
    localparam int COUNT_W      = 17;
    localparam int SET_SIZE_W   = 7;

    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 24;

    localparam logic [SET_SIZE_W-1:0] SET_SIZE_RST = 7'd64;
    localparam logic [COUNT_W-1:0]    COUNT_MAX    = 17'h1FFFF;

    // defaults for the top-level parameters
    localparam int MAX_VERTICES_DEF = 64;
    localparam int VERTEX_BITS_DEF  = 32;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CONTRIB = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOTAL   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_LATCH_A,
        ST_LOAD_J,
        ST_LATCH_J,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // which triple loop the sequencer is walking
    typedef enum logic [1:0] {
        PH_APEX,
        PH_LEG,
        PH_TOTAL
    } t_phase;

    // sequencer to pair unit controls
    typedef struct packed {
        logic clr;          // new item: take candidate, clear count and flag
        logic apex_mem;     // apex <= memory word
        logic da_mem_apex;  // first difference <= memory word ^ apex
        logic da_mem_cand;  // first difference <= memory word ^ candidate
        logic pres;         // compare memory word with candidate
        logic chk;          // memory word is a second leg to test
    } t_unit_ctl;

endpackage

FILE: hdl/hcrac_ram.sv
// hcrac_ram: generic single-port-write, single-port-read RAM with registered read
// no dependencies

module hcrac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/hcrac_pair_unit.sv
// hcrac_pair_unit: shared pair test, saturating triple counter and presence flag
// depends on hcrac_pkg; driven by hcrac_seq, fed by the vertex memory read port

module hcrac_pair_unit #(
    parameter int VERTEX_BITS = hcrac_pkg::VERTEX_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hcrac_pkg::t_unit_ctl         i_ctl,
    input  logic [VERTEX_BITS-1:0]       i_cand,
    input  logic [VERTEX_BITS-1:0]       i_rdata,
    output logic [hcrac_pkg::COUNT_W-1:0] o_count,
    output logic                         o_present
);

    logic [VERTEX_BITS-1:0]        r_cand, n_cand;
    logic [VERTEX_BITS-1:0]        r_apex, n_apex;
    logic [VERTEX_BITS-1:0]        r_da, n_da;
    logic [hcrac_pkg::COUNT_W-1:0] r_acc, n_acc;
    logic                          r_pres, n_pres;
    logic                          hit;

    always_comb begin
        // right angle at the apex: the two differences share no set bit
        hit    = ((r_da & (i_rdata ^ r_apex)) == '0);
        n_cand = r_cand;
        n_apex = r_apex;
        n_da   = r_da;
        n_acc  = r_acc;
        n_pres = r_pres;
        if (i_ctl.clr) begin
            n_cand = i_cand;
            n_apex = i_cand;
            n_acc  = '0;
            n_pres = 1'b0;
        end else begin
            if (i_ctl.apex_mem) begin
                n_apex = i_rdata;
            end
            if (i_ctl.da_mem_apex) begin
                n_da = i_rdata ^ r_apex;
            end else if (i_ctl.da_mem_cand) begin
                n_da = i_rdata ^ r_cand;
            end
            if (i_ctl.chk && hit && (r_acc != hcrac_pkg::COUNT_MAX)) begin
                n_acc = r_acc + 1'b1;
            end
            if (i_ctl.pres && (i_rdata == r_cand)) begin
                n_pres = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pres <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_pres <= n_pres;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_apex <= n_apex;
        r_da   <= n_da;
    end

    assign o_count   = r_acc;
    assign o_present = r_pres;

endmodule

FILE: hdl/hcrac_seq.sv
// hcrac_seq: loop sequencer over apex and leg positions, at most one memory read a cycle
// depends on hcrac_pkg; drives the vertex memory read address and hcrac_pair_unit

module hcrac_seq #(
    parameter int MAX_VERTICES = hcrac_pkg::MAX_VERTICES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_fire,
    input  logic [hcrac_pkg::KIND_W-1:0]        i_kind,
    input  logic [hcrac_pkg::INDEX_W-1:0]       i_pos,
    input  logic [hcrac_pkg::SET_SIZE_W-1:0]    i_set_size,
    input  logic                                i_out_free,
    output logic                                o_ready,
    output logic [$clog2(MAX_VERTICES)-1:0]     o_rd_addr,
    output hcrac_pkg::t_unit_ctl                o_ctl,
    output logic                                o_res_load
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int PW = (CW > hcrac_pkg::INDEX_W) ? CW : hcrac_pkg::INDEX_W;
    localparam int SW = (CW > hcrac_pkg::SET_SIZE_W) ? CW : hcrac_pkg::SET_SIZE_W;

    hcrac_pkg::t_state r_state, n_state;
    hcrac_pkg::t_phase r_ph, n_ph;

    logic [CW-1:0]                     r_a, n_a;
    logic [CW-1:0]                     r_b, n_b;
    logic [CW-1:0]                     r_j, n_j;
    logic [CW-1:0]                     r_k, n_k;
    logic [hcrac_pkg::INDEX_W-1:0]     r_pos, n_pos;
    logic                              r_chk, n_chk;
    logic [CW-1:0]                     k_in;
    logic                              a_is_pos, b_is_pos, j_is_pos, a_is_j, b_is_j;
    logic                              skip_a, skip_b;

    always_comb begin
        k_in = (SW'(i_set_size) > SW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(i_set_size);

        a_is_pos = (PW'(r_a) == PW'(r_pos));
        b_is_pos = (PW'(r_b) == PW'(r_pos));
        j_is_pos = (PW'(r_j) == PW'(r_pos));
        a_is_j   = (r_a == r_j);
        b_is_j   = (r_b == r_j);

        case (r_ph)
            hcrac_pkg::PH_APEX: begin
                skip_a = a_is_pos;
                skip_b = b_is_pos;
            end
            hcrac_pkg::PH_LEG: begin
                skip_a = 1'b0;
                skip_b = b_is_pos || b_is_j;
            end
            default: begin
                skip_a = a_is_j;
                skip_b = b_is_j;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_ph       = r_ph;
        n_a        = r_a;
        n_b        = r_b;
        n_j        = r_j;
        n_k        = r_k;
        n_pos      = r_pos;
        n_chk      = 1'b0;
        o_ctl      = '0;
        o_ctl.chk  = r_chk;
        o_rd_addr  = r_b[AW-1:0];
        o_res_load = 1'b0;

        case (r_state)
            hcrac_pkg::ST_IDLE: begin
                if (i_in_fire) begin
                    o_ctl.clr = 1'b1;
                    n_pos     = i_pos;
                    n_k       = k_in;
                    n_a       = '0;
                    n_b       = '0;
                    n_j       = '0;
                    case (i_kind)
                        hcrac_pkg::KIND_CONTRIB: begin
                            n_ph    = hcrac_pkg::PH_APEX;
                            n_state = hcrac_pkg::ST_LOAD_A;
                        end
                        hcrac_pkg::KIND_TOTAL: begin
                            n_ph    = hcrac_pkg::PH_TOTAL;
                            n_state = hcrac_pkg::ST_LOAD_J;
                        end
                        default: begin
                            n_state = hcrac_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            hcrac_pkg::ST_LOAD_A: begin
                if (r_a >= r_k) begin
                    if (r_ph == hcrac_pkg::PH_APEX) begin
                        // candidate-as-apex done, now candidate as leg
                        n_ph = hcrac_pkg::PH_LEG;
                        n_j  = '0;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                    n_state = hcrac_pkg::ST_LOAD_J;
                end else if (skip_a) begin
                    n_a = r_a + 1'b1;
                end else begin
                    o_rd_addr = r_a[AW-1:0];
                    n_state   = hcrac_pkg::ST_LATCH_A;
                end
            end
            hcrac_pkg::ST_LATCH_A: begin
                o_ctl.da_mem_apex = 1'b1;
                n_b               = r_a + 1'b1;
                n_state           = hcrac_pkg::ST_SCAN;
            end
            hcrac_pkg::ST_LOAD_J: begin
                if (r_j >= r_k) begin
                    n_state = hcrac_pkg::ST_FINISH;
                end else begin
                    o_rd_addr = r_j[AW-1:0];
                    n_state   = hcrac_pkg::ST_LATCH_J;
                end
            end
            hcrac_pkg::ST_LATCH_J: begin
                o_ctl.apex_mem = 1'b1;
                if (r_ph == hcrac_pkg::PH_LEG) begin
                    // presence covers every active entry, the replaced one too
                    o_ctl.pres = 1'b1;
                    if (j_is_pos) begin
                        n_j     = r_j + 1'b1;
                        n_state = hcrac_pkg::ST_LOAD_J;
                    end else begin
                        o_ctl.da_mem_cand = 1'b1;
                        n_b               = '0;
                        n_state           = hcrac_pkg::ST_SCAN;
                    end
                end else begin
                    n_a     = '0;
                    n_state = hcrac_pkg::ST_LOAD_A;
                end
            end
            hcrac_pkg::ST_SCAN: begin
                if (r_b >= r_k) begin
                    // last pending test is counted in this cycle
                    if (r_ph == hcrac_pkg::PH_LEG) begin
                        n_j     = r_j + 1'b1;
                        n_state = hcrac_pkg::ST_LOAD_J;
                    end else begin
                        n_a     = r_a + 1'b1;
                        n_state = hcrac_pkg::ST_LOAD_A;
                    end
                end else begin
                    o_rd_addr = r_b[AW-1:0];
                    n_chk     = !skip_b;
                    n_b       = r_b + 1'b1;
                end
            end
            hcrac_pkg::ST_FINISH: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = hcrac_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hcrac_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcrac_pkg::ST_IDLE;
            r_ph    <= hcrac_pkg::PH_APEX;
            r_a     <= '0;
            r_b     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_a     <= n_a;
            r_b     <= n_b;
            r_j     <= n_j;
            r_k     <= n_k;
            r_chk   <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

    assign o_ready = (r_state == hcrac_pkg::ST_IDLE);

    // no pair test may be left in flight when an item finishes
    a_idle_no_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hcrac_pkg::ST_IDLE) |-> !r_chk)
        else $error("pair test pending while idle");

    // a test always follows in the cycle after a scan read
    a_chk_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> ($past(r_state) == hcrac_pkg::ST_SCAN))
        else $error("pair test without scan read");

    // loop counters never run past the active count
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != hcrac_pkg::ST_IDLE) |-> ((r_a <= r_k) && (r_b <= r_k) && (r_j <= r_k)))
        else $error("loop counter beyond active count");

    // a result is loaded only with room in the output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> (i_out_free && (r_state == hcrac_pkg::ST_FINISH)))
        else $error("result loaded while output busy");

endmodule

FILE: hdl/hypercube_right_angle_counter.sv
// hypercube_right_angle_counter: top level, stream ports, set size register,
// vertex memory and output register; depends on hcrac_pkg, hcrac_ram, hcrac_seq, hcrac_pair_unit

// Keeps up to MAX_VERTICES hypercube vertices in a memory and counts right-angle
// triples among the first k = min(set_size, MAX_VERTICES) entries. One item is
// taken at a time; s_axis_tready is high only while the sequencer is idle, and
// the result sits in an output register so the next item can be taken while
// it waits. A single pair test unit fed by at most one memory read per cycle
// does all the work, so the cost is set by the number of pair tests. No
// clearing pass is done after reset: entries must be written before they are
// read.

module hypercube_right_angle_counter #(
    parameter int MAX_VERTICES = hcrac_pkg::MAX_VERTICES_DEF,
    parameter int VERTEX_BITS  = hcrac_pkg::VERTEX_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_set_size_we,
    input  logic [hcrac_pkg::SET_SIZE_W-1:0]     i_set_size_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [5:0] index, [37:6] vertex, [39:38] zero
    input  logic [hcrac_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] kind
    input  logic [hcrac_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [16:0] count, [17] already_present, [23:18] zero
    output logic [hcrac_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int PW = (CW > hcrac_pkg::INDEX_W) ? CW : hcrac_pkg::INDEX_W;

    logic [hcrac_pkg::SET_SIZE_W-1:0] r_set_size;
    logic                             r_ovalid, n_ovalid;
    logic [hcrac_pkg::COUNT_W-1:0]    r_ocount, n_ocount;
    logic                             r_opres, n_opres;

    logic                             in_fire;
    logic                             out_free;
    logic                             ready;
    logic                             res_load;
    logic                             wr_en;
    logic [hcrac_pkg::INDEX_W-1:0]    in_index;
    logic [VERTEX_BITS-1:0]           in_vertex;
    logic [AW-1:0]                    rd_addr;
    logic [VERTEX_BITS-1:0]           rd_data;
    hcrac_pkg::t_unit_ctl             unit_ctl;
    logic [hcrac_pkg::COUNT_W-1:0]    unit_count;
    logic                             unit_present;

    assign in_index  = s_axis_tdata[hcrac_pkg::INDEX_W-1:0];
    // vertex bits above VERTEX_BITS are dropped
    assign in_vertex = s_axis_tdata[hcrac_pkg::INDEX_W +: VERTEX_BITS];

    assign s_axis_tready = ready;
    assign in_fire       = s_axis_tvalid && ready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign wr_en         = in_fire && (s_axis_tuser == hcrac_pkg::KIND_WRITE)
                           && (PW'(in_index) < PW'(MAX_VERTICES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size <= hcrac_pkg::SET_SIZE_RST;
        end else if (i_set_size_we) begin
            r_set_size <= i_set_size_wdata;
        end
    end

    hcrac_ram #(
        .WIDTH (VERTEX_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(in_index)),
        .i_wdata (in_vertex),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    hcrac_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_kind     (s_axis_tuser),
        .i_pos      (in_index),
        .i_set_size (r_set_size),
        .i_out_free (out_free),
        .o_ready    (ready),
        .o_rd_addr  (rd_addr),
        .o_ctl      (unit_ctl),
        .o_res_load (res_load)
    );

    hcrac_pair_unit #(
        .VERTEX_BITS (VERTEX_BITS)
    ) u_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (unit_ctl),
        .i_cand    (in_vertex),
        .i_rdata   (rd_data),
        .o_count   (unit_count),
        .o_present (unit_present)
    );

    always_comb begin
        n_ovalid = r_ovalid;
        n_ocount = r_ocount;
        n_opres  = r_opres;
        if (res_load) begin
            n_ovalid = 1'b1;
            n_ocount = unit_count;
            n_opres  = unit_present;
        end else if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ocount <= n_ocount;
        r_opres  <= n_opres;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(hcrac_pkg::OUT_DATA_W - hcrac_pkg::COUNT_W - 1){1'b0}},
                            r_opres, r_ocount};

endmodule

FILE: tb/tb_hypercube_right_angle_counter.sv
// tb_hypercube_right_angle_counter: self-checking bench for the right-angle triple counter,
// with a scoreboard class that tracks the vertex store and predicts each count and flag
// depends on hcrac_pkg and hypercube_right_angle_counter

module tb_hypercube_right_angle_counter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KIND_W       = hcrac_pkg::KIND_W;
    localparam int INDEX_W      = hcrac_pkg::INDEX_W;
    localparam int VERTEX_W     = hcrac_pkg::VERTEX_W;
    localparam int COUNT_W      = hcrac_pkg::COUNT_W;
    localparam int SET_SIZE_W   = hcrac_pkg::SET_SIZE_W;
    localparam int IN_DATA_W    = hcrac_pkg::IN_DATA_W;
    localparam int OUT_DATA_W   = hcrac_pkg::OUT_DATA_W;

    localparam int                MAX_VERTICES = hcrac_pkg::MAX_VERTICES_DEF;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
    // watchdog quiet limit, long enough for a total query over 64 entries
    localparam int                QUIET_LIMIT  = 600_000;

    class triple_scoreboard;
        typedef struct {
            logic [COUNT_W-1:0] count;
            logic               present;
        } t_answer;

        bit [VERTEX_W-1:0] store [MAX_VERTICES];
        int unsigned       active_k = MAX_VERTICES;
        t_answer           answers_due [$];
        int unsigned       errors = 0;

        function void set_size(logic [SET_SIZE_W-1:0] size);
            active_k = (size > MAX_VERTICES) ? MAX_VERTICES : size;
        endfunction

        function int unsigned pending();
            return answers_due.size();
        endfunction

        function logic [COUNT_W-1:0] clip_count(int unsigned n);
            return (n > hcrac_pkg::COUNT_MAX) ? hcrac_pkg::COUNT_MAX : n[COUNT_W-1:0];
        endfunction

        // triples touched by cand standing at pos, as apex and then as leg
        function int unsigned triples_touched(int unsigned pos, bit [VERTEX_W-1:0] cand);
            int unsigned n;
            n = 0;
            for (int unsigned a = 0; a < active_k; a++) begin
                if (a == pos) continue;
                for (int unsigned b = a + 1; b < active_k; b++) begin
                    if (b != pos && ((store[a] ^ cand) & (store[b] ^ cand)) == '0) n++;
                end
            end
            for (int unsigned j = 0; j < active_k; j++) begin
                if (j == pos) continue;
                for (int unsigned b = 0; b < active_k; b++) begin
                    if (b == pos || b == j) continue;
                    if (((cand ^ store[j]) & (store[b] ^ store[j])) == '0) n++;
                end
            end
            return n;
        endfunction

        function int unsigned total_triples();
            int unsigned n;
            n = 0;
            for (int unsigned j = 0; j < active_k; j++) begin
                for (int unsigned a = 0; a < active_k; a++) begin
                    if (a == j) continue;
                    for (int unsigned b = a + 1; b < active_k; b++) begin
                        if (b == j) continue;
                        if (((store[a] ^ store[j]) & (store[b] ^ store[j])) == '0) n++;
                    end
                end
            end
            return n;
        endfunction

        function bit holds(bit [VERTEX_W-1:0] cand);
            for (int unsigned i = 0; i < active_k; i++) begin
                if (store[i] == cand) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_item(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                                logic [VERTEX_W-1:0] vx);
            t_answer ans;
            ans.count   = '0;
            ans.present = 1'b0;
            case (kind)
                hcrac_pkg::KIND_WRITE: begin
                    store[idx] = vx;
                end
                hcrac_pkg::KIND_CONTRIB: begin
                    ans.count   = clip_count(triples_touched(idx, vx));
                    ans.present = holds(vx);
                end
                hcrac_pkg::KIND_TOTAL: begin
                    ans.count = clip_count(total_triples());
                end
                default: ;
            endcase
            answers_due.push_back(ans);
        endfunction

        function void check_result(logic [COUNT_W-1:0] count, logic present);
            t_answer want;
            if (answers_due.size() == 0) begin
                $display("%0t: result with nothing due, count %0d present %0b",
                         $time, count, present);
                errors++;
                return;
            end
            want = answers_due.pop_front();
            if (count !== want.count) begin
                $display("%0t: count mismatch, expected %0d, got %0d",
                         $time, want.count, count);
                errors++;
            end
            if (present !== want.present) begin
                $display("%0t: already_present mismatch, expected %0b, got %0b",
                         $time, want.present, present);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_set_size_we;
    logic [SET_SIZE_W-1:0]   i_set_size_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;   // [5:0] index, [37:6] vertex, [39:38] zero
    logic [KIND_W-1:0]       s_axis_tuser;   // [1:0] kind
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;   // [16:0] count, [17] already_present

    triple_scoreboard  sb = new;
    bit                written [MAX_VERTICES];
    bit                gaps_on;
    int unsigned       quiet_cycles = 0;
    logic [VERTEX_W-1:0] cluster_base;
    int unsigned       cluster_shift;

    hypercube_right_angle_counter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_set_size_we    (i_set_size_we),
        .i_set_size_wdata (i_set_size_wdata),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata[COUNT_W-1:0], m_axis_tdata[COUNT_W]);
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_item(s_axis_tuser, s_axis_tdata[INDEX_W-1:0],
                         s_axis_tdata[INDEX_W +: VERTEX_W]);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // mostly vertices near a common base so that differences are often disjoint
    function automatic logic [VERTEX_W-1:0] pick_vertex();
        if ($urandom_range(3) == 0) return $urandom();
        return cluster_base ^ (($urandom() & 32'h3F) << cluster_shift);
    endfunction

    function automatic logic [VERTEX_W-1:0] pick_candidate();
        if (sb.active_k > 0 && $urandom_range(9) < 3) begin
            return sb.store[$urandom_range(sb.active_k - 1)];
        end
        return pick_vertex();
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        if (sb.active_k > 0 && $urandom_range(9) < 7) begin
            return INDEX_W'($urandom_range(sb.active_k - 1));
        end
        return INDEX_W'($urandom_range(MAX_VERTICES - 1));
    endfunction

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                             input logic [VERTEX_W-1:0] vx);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 8) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, vx, idx};
        s_axis_tuser  = kind;
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == hcrac_pkg::KIND_WRITE) written[idx] = 1'b1;
    endtask

    // register writes only once every result is back
    task automatic set_set_size(input logic [SET_SIZE_W-1:0] size);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        i_set_size_we    = 1'b1;
        i_set_size_wdata = size;
        @(negedge i_clk);
        i_set_size_we = 1'b0;
        sb.set_size(size);
    endtask

    // every active entry must be written before a query reads it
    task automatic fill_active();
        for (int i = 0; i < sb.active_k; i++) begin
            if (!written[i]) send_item(hcrac_pkg::KIND_WRITE, INDEX_W'(i), pick_vertex());
        end
    endtask

    task automatic random_item(output bit counted);
        int unsigned r;
        r = $urandom_range(99);
        counted = 1'b1;
        if (r < 35) begin
            send_item(hcrac_pkg::KIND_WRITE, pick_index(), pick_vertex());
        end else if (r < 75) begin
            send_item(hcrac_pkg::KIND_CONTRIB, pick_index(), pick_candidate());
        end else if (r < 90) begin
            send_item(hcrac_pkg::KIND_TOTAL, INDEX_W'($urandom()), $urandom());
        end else begin
            send_item(KIND_UNUSED, INDEX_W'($urandom()), $urandom());
            counted = 1'b0;
        end
    endtask

    initial begin : stimulus
        int  sent;
        bit  counted;
        i_rst_n          = 1'b0;
        i_set_size_we    = 1'b0;
        i_set_size_wdata = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = hcrac_pkg::KIND_WRITE;
        gaps_on          = 1'b1;
        cluster_base     = $urandom();
        cluster_shift    = $urandom_range(26);
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: smallest legal set, field extremes, every kind
        set_set_size(7'd3);
        send_item(hcrac_pkg::KIND_WRITE, 6'd0, 32'h0000_0000);
        send_item(hcrac_pkg::KIND_WRITE, 6'd1, 32'hFFFF_FFFF);
        send_item(hcrac_pkg::KIND_WRITE, 6'd2, 32'h0000_0001);
        send_item(hcrac_pkg::KIND_WRITE, 6'd63, 32'h5555_AAAA);
        send_item(hcrac_pkg::KIND_CONTRIB, 6'd0, 32'hFFFF_FFFF);
        send_item(hcrac_pkg::KIND_CONTRIB, 6'd2, 32'h0000_0003);
        // position outside the active set
        send_item(hcrac_pkg::KIND_CONTRIB, 6'd63, 32'h0000_0002);
        send_item(hcrac_pkg::KIND_TOTAL, 6'd0, 32'h0000_0000);
        send_item(KIND_UNUSED, 6'd63, 32'hFFFF_FFFF);
        send_item(hcrac_pkg::KIND_WRITE, 6'd2, 32'h8000_0000);
        send_item(hcrac_pkg::KIND_TOTAL, 6'd63, 32'hFFFF_FFFF);
        // set sizes below three
        set_set_size(7'd0);
        send_item(hcrac_pkg::KIND_CONTRIB, 6'd0, 32'h0000_0000);
        send_item(hcrac_pkg::KIND_TOTAL, 6'd0, 32'h0000_0000);
        set_set_size(7'd2);
        send_item(hcrac_pkg::KIND_CONTRIB, 6'd5, 32'h0000_0001);
        send_item(hcrac_pkg::KIND_TOTAL, 6'd1, 32'h0000_0000);
        set_set_size(7'd1);
        send_item(hcrac_pkg::KIND_CONTRIB, 6'd0, 32'h0000_0000);
        send_item(hcrac_pkg::KIND_TOTAL, 6'd0, 32'h0000_0000);

        // random phases on small sets, one of them without any idling
        for (int p = 0; p < 5; p++) begin
            gaps_on       = (p != 2);
            cluster_base  = $urandom();
            cluster_shift = $urandom_range(26);
            set_set_size((p == 3) ? SET_SIZE_W'($urandom_range(2))
                                  : SET_SIZE_W'($urandom_range(3, 10)));
            fill_active();
            sent = 0;
            while (sent < 14) begin
                random_item(counted);
                if (counted) sent++;
            end
        end

        // full store: oversized register value, then the largest legal one
        gaps_on       = 1'b1;
        cluster_base  = $urandom();
        cluster_shift = $urandom_range(26);
        set_set_size(7'd127);
        fill_active();
        repeat (3) send_item(hcrac_pkg::KIND_CONTRIB, INDEX_W'($urandom()), pick_candidate());
        send_item(hcrac_pkg::KIND_TOTAL, INDEX_W'($urandom()), $urandom());
        set_set_size(hcrac_pkg::SET_SIZE_RST);
        send_item(hcrac_pkg::KIND_WRITE, INDEX_W'($urandom()), pick_vertex());
        repeat (2) send_item(hcrac_pkg::KIND_CONTRIB, INDEX_W'($urandom()), pick_candidate());
        send_item(hcrac_pkg::KIND_TOTAL, INDEX_W'($urandom()), $urandom());

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/hcrac_pkg.sv
hdl/hcrac_ram.sv
hdl/hcrac_pair_unit.sv
hdl/hcrac_seq.sv
hdl/hypercube_right_angle_counter.sv
tb/tb_hypercube_right_angle_counter.sv
